FILE: src/psu_pkg.sv
// Shared types, codes and arithmetic helpers for the particle swarm update engine.
// Used by psu_front, psu_back and particle_swarm_update; depends on nothing else.
package psu_pkg;

    localparam int PARTICLES_DEF = 128;
    localparam int DIMS_DEF      = 256;

    // Command codes as they arrive on the stream.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STEP   = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_INERTIA   = 2'd0;
    localparam logic [1:0] REG_COGNITIVE = 2'd1;
    localparam logic [1:0] REG_SOCIAL    = 2'd2;
    localparam logic [1:0] REG_TARGET    = 2'd3;

    localparam logic [15:0] INERTIA_RST   = 16'd2949;
    localparam logic [15:0] COGNITIVE_RST = 16'd5816;
    localparam logic [15:0] SOCIAL_RST    = 16'd5816;
    localparam logic [31:0] TARGET_RST    = 32'd0;

    // What the back end has to do with an item.
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_STEP   = 2'd2,
        KIND_REPORT = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [6:0]         particle;
        logic [7:0]         dimension;
        logic signed [31:0] load_value;
        logic [31:0]        fitness;
        logic [15:0]        rand_personal;
        logic [15:0]        rand_global;
    } t_job;

    typedef struct packed {
        logic [15:0] inertia;
        logic [15:0] cognitive_gain;
        logic [15:0] social_gain;
        logic [31:0] target_score;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic               personal_improved;
        logic               global_improved;
        logic [31:0]        best_fitness;
        logic               target_reached;
    } t_result;

    // Q4.28 product rounded half up to Q4.12; the operand is never negative.
    function automatic logic [15:0] rnd16(input logic signed [49:0] p);
        logic signed [49:0] t;
        t = p + 50'sd32768;
        return t[31:16];
    endfunction

    // Round half up by 12 bits, floor on the sign-extended value.
    function automatic logic signed [37:0] rnd12(input logic signed [49:0] p);
        logic signed [49:0] t;
        t = p + 50'sd2048;
        return t[49:12];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] s);
        logic signed [31:0] r;
        if (s > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (s < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

FILE: src/psu_front.sv
// Front end: takes items from the input stream, classifies them and queues them.
// Depends on psu_pkg for the job type and command codes.
module psu_front #(
    parameter int PARTICLES = 128,
    parameter int DIMS      = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_cmd,
    input  logic [110:0]  i_fields,
    output logic          o_job_valid,
    output psu_pkg::t_job o_job,
    input  logic          i_job_pop
);
    import psu_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_in_range_p, w_in_range_d, w_push;

    // Classify the incoming item.
    always_comb begin
        w_job.particle      = i_fields[6:0];
        w_job.dimension     = i_fields[14:7];
        w_job.load_value    = i_fields[46:15];
        w_job.fitness       = i_fields[78:47];
        w_job.rand_personal = i_fields[94:79];
        w_job.rand_global   = i_fields[110:95];
        w_in_range_p = 32'(w_job.particle) < PARTICLES;
        w_in_range_d = 32'(w_job.dimension) < DIMS;
        case (i_cmd)
            CMD_LOAD:   w_job.kind = (w_in_range_p && w_in_range_d) ? KIND_LOAD : KIND_NONE;
            CMD_STEP:   w_job.kind = (w_in_range_p && w_in_range_d) ? KIND_STEP : KIND_NONE;
            CMD_REPORT: w_job.kind = w_in_range_p ? KIND_REPORT : KIND_NONE;
            default:    w_job.kind = KIND_NONE;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    // Two-entry queue between front and back.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_pop);
        end
    end

endmodule

FILE: src/psu_back.sv
// Back end: executes queued jobs against the particle stores with one shared multiplier.
// Depends on psu_pkg for job, configuration and result types and arithmetic helpers.
module psu_back #(
    parameter int PARTICLES = 128,
    parameter int DIMS      = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psu_pkg::t_cfg   i_cfg,
    input  logic            i_job_valid,
    input  psu_pkg::t_job   i_job,
    output logic            o_job_pop,
    output logic            o_res_valid,
    output psu_pkg::t_result o_res,
    input  logic            i_res_ready
);
    import psu_pkg::*;

    localparam int DEPTH = PARTICLES * DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(PARTICLES);
    localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int CW    = $clog2(DIMS + 1);

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_LOAD  = 15'h0002,
        S_SREAD = 15'h0004,
        S_M1    = 15'h0008,
        S_M2    = 15'h0010,
        S_M3    = 15'h0020,
        S_M4    = 15'h0040,
        S_M5    = 15'h0080,
        S_SUM   = 15'h0100,
        S_POS   = 15'h0200,
        S_FREAD = 15'h0400,
        S_FCMP  = 15'h0800,
        S_CRD   = 15'h1000,
        S_CWR   = 15'h2000,
        S_OUT   = 15'h4000
    } t_state;

    // Stores; contents are undefined until written.
    logic signed [31:0] pos_mem [DEPTH];
    logic signed [31:0] vel_mem [DEPTH];
    logic signed [31:0] pb_mem  [DEPTH];
    logic signed [31:0] gb_mem  [DIMS];
    logic [31:0]        fit_mem [PARTICLES];

    t_state r_state, n_state;
    t_job   r_job;
    logic [CW-1:0] r_cnt;
    logic [PARTICLES-1:0] r_seen;
    logic [31:0] r_gfit;
    logic        r_gseen;

    logic signed [31:0] rd_x, rd_v, rd_pb, rd_gb;
    logic [31:0]        rd_fit;

    logic signed [49:0] r_prod;
    logic [15:0]        r_f1, r_f2;
    logic signed [39:0] r_acc;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_rpos, r_rvel;
    logic               r_pimp, r_gimp;

    logic [AW-1:0]      w_addr;
    logic [PW-1:0]      w_pidx;
    logic [DW-1:0]      w_didx, w_cidx;
    logic signed [32:0] m_a;
    logic signed [16:0] m_b;
    logic signed [49:0] m_p;
    logic signed [31:0] w_npos;
    logic               w_pbetter, w_gbetter;
    logic               pos_we, pb_we, gb_we;
    logic signed [31:0] pos_wd, vel_wd, pb_wd;

    // Element address: the job's element, or the copy counter during a vector copy.
    always_comb begin
        w_pidx = PW'(r_job.particle);
        w_didx = DW'(r_job.dimension);
        w_cidx = DW'(r_cnt);
        if (r_state == S_CRD || r_state == S_CWR) begin
            w_addr = AW'(32'(r_job.particle) * DIMS + 32'(r_cnt));
        end else begin
            w_addr = AW'(32'(r_job.particle) * DIMS + 32'(r_job.dimension));
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_M1: begin
                m_a = 33'(i_cfg.cognitive_gain);
                m_b = 17'(r_job.rand_personal);
            end
            S_M2: begin
                m_a = 33'(i_cfg.social_gain);
                m_b = 17'(r_job.rand_global);
            end
            S_M3: begin
                m_a = 33'(rd_v);
                m_b = 17'(i_cfg.inertia);
            end
            S_M4: begin
                m_a = 33'(rd_pb) - 33'(rd_x);
                m_b = 17'(r_f1);
            end
            S_M5: begin
                m_a = 33'(rd_gb) - 33'(rd_x);
                m_b = 17'(r_f2);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = 50'(m_a) * 50'(m_b);

    assign w_npos    = sat32(40'(rd_x) + 40'(r_vel));
    assign w_pbetter = !r_seen[w_pidx] || (r_job.fitness > rd_fit);
    assign w_gbetter = !r_gseen || (r_job.fitness > r_gfit);

    // Store write controls.
    always_comb begin
        pos_we = (r_state == S_LOAD) || (r_state == S_POS);
        pos_wd = (r_state == S_LOAD) ? r_job.load_value : w_npos;
        vel_wd = (r_state == S_LOAD) ? 32'sd0 : r_vel;
        pb_we  = (r_state == S_LOAD) || (r_state == S_CWR);
        pb_wd  = (r_state == S_LOAD) ? r_job.load_value : rd_x;
        gb_we  = (r_state == S_CWR) && r_gimp;
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[w_addr] <= pos_wd;
            vel_mem[w_addr] <= vel_wd;
        end
        if (pb_we) begin
            pb_mem[w_addr] <= pb_wd;
        end
        if (gb_we) begin
            gb_mem[w_cidx] <= rd_x;
        end
        if (r_state == S_FCMP && w_pbetter) begin
            fit_mem[w_pidx] <= r_job.fitness;
        end
        rd_x   <= pos_mem[w_addr];
        rd_v   <= vel_mem[w_addr];
        rd_pb  <= pb_mem[w_addr];
        rd_gb  <= gb_mem[w_didx];
        rd_fit <= fit_mem[w_pidx];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        KIND_LOAD:   n_state = S_LOAD;
                        KIND_STEP:   n_state = S_SREAD;
                        KIND_REPORT: n_state = S_FREAD;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_LOAD:  n_state = S_OUT;
            S_SREAD: n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_SUM;
            S_SUM:   n_state = S_POS;
            S_POS:   n_state = S_OUT;
            S_FREAD: n_state = S_FCMP;
            S_FCMP:  n_state = w_pbetter ? S_CRD : S_OUT;
            S_CRD:   n_state = S_CWR;
            S_CWR:   n_state = (32'(r_cnt) == DIMS - 1) ? S_OUT : S_CRD;
            S_OUT:   n_state = i_res_ready ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seen  <= '0;
            r_gfit  <= '0;
            r_gseen <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FCMP && w_pbetter) begin
                r_seen[w_pidx] <= 1'b1;
                if (w_gbetter) begin
                    r_gseen <= 1'b1;
                    r_gfit  <= r_job.fitness;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_rpos <= '0;
                r_rvel <= '0;
                r_pimp <= 1'b0;
                r_gimp <= 1'b0;
                r_cnt  <= '0;
            end
            S_LOAD: begin
                r_rpos <= r_job.load_value;
                r_rvel <= '0;
            end
            S_M2:  r_f1  <= rnd16(r_prod);
            S_M3:  r_f2  <= rnd16(r_prod);
            S_M4:  r_acc <= 40'(rnd12(r_prod));
            S_M5:  r_acc <= r_acc + 40'(rnd12(r_prod));
            S_SUM: r_vel <= sat32(r_acc + 40'(rnd12(r_prod)));
            S_POS: begin
                r_rpos <= w_npos;
                r_rvel <= r_vel;
            end
            S_FCMP: begin
                r_pimp <= w_pbetter;
                r_gimp <= w_pbetter && w_gbetter;
            end
            S_CWR: r_cnt <= r_cnt + CW'(1);
            default: begin
            end
        endcase
    end

    // Result towards the output stage.
    always_comb begin
        o_res_valid             = (r_state == S_OUT);
        o_res.new_position      = r_rpos;
        o_res.new_velocity      = r_rvel;
        o_res.personal_improved = r_pimp;
        o_res.global_improved   = r_gimp;
        o_res.best_fitness      = r_gfit;
        o_res.target_reached    = r_gseen && (r_gfit == i_cfg.target_score);
    end

endmodule

FILE: src/particle_swarm_update.sv
// Particle swarm update engine: one result item for every input item, in order.
// A report also copies the position vector into the personal best when the personal best rises.
// Items are served one at a time: the back-end sequencer and its single multiplier
// take no new item until the current result has been handed to the output register;
// a two-entry queue and the output register decouple it.
// Synchronous active-low reset clears control, best fitness and seen flags; stores are not cleared.
module particle_swarm_update #(
    parameter int PARTICLES = psu_pkg::PARTICLES_DEF,
    parameter int DIMS      = psu_pkg::DIMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: particle[6:0], dimension[14:7], load_value[46:15],
    // fitness[78:47], rand_personal[94:79], rand_global[110:95], zero [111]
    input  logic [111:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]   s_tuser,
    // Output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: new_position[31:0], new_velocity[63:32], personal_improved[64],
    // global_improved[65], best_fitness[97:66], target_reached[98], zero [103:99]
    output logic [103:0] m_tdata,
    // Configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import psu_pkg::*;

    t_cfg    r_cfg;
    t_job    w_job;
    t_result w_res;
    logic    w_job_valid, w_job_pop, w_res_valid, w_res_ready;
    logic    r_m_valid;
    logic [103:0] r_m_data;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inertia        <= INERTIA_RST;
            r_cfg.cognitive_gain <= COGNITIVE_RST;
            r_cfg.social_gain    <= SOCIAL_RST;
            r_cfg.target_score   <= TARGET_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INERTIA:   r_cfg.inertia        <= i_cfg_data[15:0];
                REG_COGNITIVE: r_cfg.cognitive_gain <= i_cfg_data[15:0];
                REG_SOCIAL:    r_cfg.social_gain    <= i_cfg_data[15:0];
                REG_TARGET:    r_cfg.target_score   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    psu_front #(.PARTICLES(PARTICLES), .DIMS(DIMS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_cmd       (s_tuser),
        .i_fields    (s_tdata[110:0]),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    psu_back #(.PARTICLES(PARTICLES), .DIMS(DIMS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // Output register.
    assign w_res_ready = !r_m_valid || m_tready;
    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_data <= {5'd0, w_res.target_reached, w_res.best_fitness,
                         w_res.global_improved, w_res.personal_improved,
                         w_res.new_velocity, w_res.new_position};
        end
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // The back end keeps its result while the output register is full.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res_ready) |=> w_res_valid)
        else $error("result dropped while output stalled");

    // A global improvement always comes with a personal one.
    a_gimp_pimp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[65]) |-> r_m_data[64])
        else $error("global improvement without personal improvement");

    // A fresh output item comes from a back-end result.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(w_res_valid))
        else $error("output item without a result");

endmodule
